@@ src/cwd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cwd_pkg;

   // request kinds carried on req_tuser
   typedef enum logic [1:0] {
      ACT_WORK    = 2'd0,
      ACT_HELLO   = 2'd1,
      ACT_READY   = 2'd2,
      ACT_GOODBYE = 2'd3
   } action_type;

   // result status carried on rsp_tuser
   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_NO_WORKERS = 2'd1,
      STATUS_QUEUE_FULL = 2'd2,
      STATUS_UNKNOWN    = 2'd3
   } status_type;

   localparam int SLOT_FIELD_BITS   = 3;
   localparam int AMOUNT_FIELD_BITS = 8;
   localparam int VALUE_FIELD_BITS  = 64;

   localparam int CREDIT_BITS = 16;
   localparam int USES_BITS   = 32;
   localparam int TBL_BITS    = CREDIT_BITS + USES_BITS;

   localparam logic [CREDIT_BITS-1:0] CREDIT_MAX = '1;
   localparam logic [USES_BITS-1:0]   USES_MAX   = '1;

   // tdata layouts, padded to whole bytes
   localparam int REQ_SLOT_LSB   = 0;
   localparam int REQ_AMOUNT_LSB = REQ_SLOT_LSB + SLOT_FIELD_BITS;
   localparam int REQ_VALUE_LSB  = REQ_AMOUNT_LSB + AMOUNT_FIELD_BITS;
   localparam int REQ_TDATA_BITS = 80;
   localparam int RSP_TDATA_BITS = 72;
   localparam int RSP_PAD_BITS   = RSP_TDATA_BITS - SLOT_FIELD_BITS - VALUE_FIELD_BITS;

endpackage

`default_nettype wire

@@ src/credit_work_dispatcher.sv @@
// Work, ready to an unknown worker and an ignored hello scan the worker table, then
// decide on a dispatch and, when they dispatch, fetch the queued value. Ready or hello to
// an existing worker first read-modify-writes its entry; hello creating a worker first
// scans for the largest uses and writes the new entry. Goodbye goes straight to the result.
// A stalled result adds its stall. The next transaction is accepted once the result is
// registered and the sequencer is idle again; the table scan reads one slot per cycle.
// Reset (synchronous, active high) clears the worker table valid bits, queue pointers,
// sequencer and output valid; the queue storage is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module credit_work_dispatcher #(
   parameter int WORKER_SLOTS = 8,
   parameter int QUEUE_DEPTH  = 16,
   parameter int VALUE_BITS   = 64
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // [2:0] worker_slot, [10:3] credit_amount, [74:11] work_value, rest zero
   input  wire  [cwd_pkg::REQ_TDATA_BITS-1:0]   req_tdata,
   // [1:0] action
   input  wire  [1:0]                           req_tuser,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // [2:0] target_worker, [66:3] sent_value, rest zero
   output logic [cwd_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata,
   // [0] dispatched, [2:1] status
   output logic [2:0]                           rsp_tuser
);

   localparam int SLOT_BITS = (WORKER_SLOTS > 1) ? $clog2(WORKER_SLOTS) : 1;
   localparam int QB        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CB        = cwd_pkg::CREDIT_BITS;
   localparam int UB        = cwd_pkg::USES_BITS;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ACT,
      ST_RMW_RD,
      ST_RMW_WR,
      ST_SCAN,
      ST_NEW_WR,
      ST_DECIDE,
      ST_FETCH,
      ST_RESULT
   } state_type;

   state_type                              state_ff, state_in;

   // latched transaction
   cwd_pkg::action_type                    act_ff, act_in;
   logic [cwd_pkg::SLOT_FIELD_BITS-1:0]    slot_ff, slot_in;
   logic [cwd_pkg::AMOUNT_FIELD_BITS-1:0]  amount_ff, amount_in;
   logic [VALUE_BITS-1:0]                  value_ff, value_in;

   logic [WORKER_SLOTS-1:0]                present_ff, present_in;
   logic [QB-1:0]                          head_ff, head_in;
   logic [QB-1:0]                          tail_ff, tail_in;
   logic [QB:0]                            count_ff, count_in;

   // scan state
   logic [SLOT_BITS:0]                     scan_cnt_ff, scan_cnt_in;
   logic                                   scan_max_ff, scan_max_in;
   logic                                   cmp_valid_ff, cmp_valid_in;
   logic [SLOT_BITS-1:0]                   cmp_idx_ff, cmp_idx_in;
   logic                                   found_ff, found_in;
   logic [SLOT_BITS-1:0]                   best_idx_ff, best_idx_in;
   logic [CB-1:0]                          best_credit_ff, best_credit_in;
   logic [UB-1:0]                          best_uses_ff, best_uses_in;
   logic [UB-1:0]                          maxu_ff, maxu_in;

   cwd_pkg::status_type                    status_ff, status_in;
   logic                                   disp_ff, disp_in;
   logic [SLOT_BITS-1:0]                   target_ff, target_in;

   logic                                   rsp_valid_ff, rsp_valid_in;
   logic                                   rsp_disp_ff, rsp_disp_in;
   logic [cwd_pkg::SLOT_FIELD_BITS-1:0]    rsp_target_ff, rsp_target_in;
   logic [cwd_pkg::VALUE_FIELD_BITS-1:0]   rsp_value_ff, rsp_value_in;
   cwd_pkg::status_type                    rsp_status_ff, rsp_status_in;

   // memories
   logic [cwd_pkg::TBL_BITS-1:0]           tbl_mem [WORKER_SLOTS];
   logic [cwd_pkg::TBL_BITS-1:0]           tbl_rd_ff;
   logic                                   tbl_we, tbl_re;
   logic [SLOT_BITS-1:0]                   tbl_waddr, tbl_raddr;
   logic [cwd_pkg::TBL_BITS-1:0]           tbl_wdata;
   logic [VALUE_BITS-1:0]                  q_mem [QUEUE_DEPTH];
   logic [VALUE_BITS-1:0]                  q_rd_ff;
   logic                                   q_we, q_re;

   logic                                   scan_go;
   logic                                   slot_ok;
   logic [SLOT_BITS-1:0]                   slot_idx;
   logic                                   known;
   logic                                   any_present;
   logic [WORKER_SLOTS-1:0]                present_left;
   logic [CB-1:0]                          rd_credit;
   logic [UB-1:0]                          rd_uses;
   logic [CB:0]                            credit_sum;
   logic                                   q_full;

   assign slot_ok     = 32'(slot_ff) < 32'(WORKER_SLOTS);
   assign slot_idx    = SLOT_BITS'(32'(slot_ff));
   assign known       = slot_ok && present_ff[slot_idx];
   assign any_present = |present_ff;
   assign rd_credit   = tbl_rd_ff[CB-1:0];
   assign rd_uses     = tbl_rd_ff[cwd_pkg::TBL_BITS-1:CB];
   assign credit_sum  = {1'b0, rd_credit} + (CB + 1)'(amount_ff);
   assign q_full      = count_ff == (QB + 1)'(QUEUE_DEPTH);

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{cwd_pkg::RSP_PAD_BITS{1'b0}}, rsp_value_ff, rsp_target_ff};
   assign rsp_tuser  = {rsp_status_ff, rsp_disp_ff};

   always_comb begin
      present_left = present_ff;
      present_left[slot_idx] = 1'b0;
   end

   always_comb begin
      state_in       = state_ff;
      act_in         = act_ff;
      slot_in        = slot_ff;
      amount_in      = amount_ff;
      value_in       = value_ff;
      present_in     = present_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      count_in       = count_ff;
      scan_cnt_in    = scan_cnt_ff;
      scan_max_in    = scan_max_ff;
      cmp_valid_in   = 1'b0;
      cmp_idx_in     = cmp_idx_ff;
      found_in       = found_ff;
      best_idx_in    = best_idx_ff;
      best_credit_in = best_credit_ff;
      best_uses_in   = best_uses_ff;
      maxu_in        = maxu_ff;
      status_in      = status_ff;
      disp_in        = disp_ff;
      target_in      = target_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_disp_in    = rsp_disp_ff;
      rsp_target_in  = rsp_target_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_status_in  = rsp_status_ff;
      tbl_we         = 1'b0;
      tbl_re         = 1'b0;
      tbl_waddr      = '0;
      tbl_raddr      = '0;
      tbl_wdata      = '0;
      q_we           = 1'b0;
      q_re           = 1'b0;
      scan_go        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               act_in    = cwd_pkg::action_type'(req_tuser);
               slot_in   = req_tdata[cwd_pkg::REQ_SLOT_LSB +: cwd_pkg::SLOT_FIELD_BITS];
               amount_in = req_tdata[cwd_pkg::REQ_AMOUNT_LSB +: cwd_pkg::AMOUNT_FIELD_BITS];
               value_in  = req_tdata[cwd_pkg::REQ_VALUE_LSB +: VALUE_BITS];
               state_in  = ST_ACT;
            end
         end
         ST_ACT: begin
            status_in = cwd_pkg::STATUS_OK;
            disp_in   = 1'b0;
            target_in = '0;
            scan_max_in = 1'b0;
            case (act_ff)
               cwd_pkg::ACT_WORK: begin
                  if (!any_present) begin
                     status_in = cwd_pkg::STATUS_NO_WORKERS;
                  end else if (q_full) begin
                     status_in = cwd_pkg::STATUS_QUEUE_FULL;
                  end else begin
                     q_we     = 1'b1;
                     tail_in  = (tail_ff == QB'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
                     count_in = count_ff + 1'b1;
                  end
                  scan_go = 1'b1;
               end
               cwd_pkg::ACT_HELLO: begin
                  if (!slot_ok) begin
                     status_in = cwd_pkg::STATUS_UNKNOWN;
                     scan_go   = 1'b1;
                  end else if (known) begin
                     state_in = ST_RMW_RD;
                  end else begin
                     // new worker: find the largest uses first
                     scan_max_in = 1'b1;
                     scan_go     = 1'b1;
                  end
               end
               cwd_pkg::ACT_READY: begin
                  if (known) begin
                     state_in = ST_RMW_RD;
                  end else begin
                     status_in = cwd_pkg::STATUS_UNKNOWN;
                     scan_go   = 1'b1;
                  end
               end
               cwd_pkg::ACT_GOODBYE: begin
                  if (known) begin
                     present_in[slot_idx] = 1'b0;
                     if (present_left == '0) begin
                        head_in  = '0;
                        tail_in  = '0;
                        count_in = '0;
                     end
                  end else begin
                     status_in = cwd_pkg::STATUS_UNKNOWN;
                  end
                  state_in = ST_RESULT;
               end
               default: begin
                  state_in = ST_RESULT;
               end
            endcase
         end
         ST_RMW_RD: begin
            tbl_re    = 1'b1;
            tbl_raddr = slot_idx;
            state_in  = ST_RMW_WR;
         end
         ST_RMW_WR: begin
            tbl_we    = 1'b1;
            tbl_waddr = slot_idx;
            if (act_ff == cwd_pkg::ACT_HELLO) begin
               tbl_wdata = {rd_uses, credit_sum[CB] ? cwd_pkg::CREDIT_MAX : credit_sum[CB-1:0]};
            end else begin
               tbl_wdata = {rd_uses,
                            (rd_credit == cwd_pkg::CREDIT_MAX) ? rd_credit : rd_credit + 1'b1};
            end
            scan_go = 1'b1;
         end
         ST_SCAN: begin
            // reads issue one slot ahead of the compare
            if (scan_cnt_ff < (SLOT_BITS + 1)'(WORKER_SLOTS)) begin
               tbl_re       = 1'b1;
               tbl_raddr    = scan_cnt_ff[SLOT_BITS-1:0];
               cmp_valid_in = 1'b1;
               cmp_idx_in   = scan_cnt_ff[SLOT_BITS-1:0];
               scan_cnt_in  = scan_cnt_ff + 1'b1;
            end else begin
               state_in = scan_max_ff ? ST_NEW_WR : ST_DECIDE;
            end
            if (cmp_valid_ff && present_ff[cmp_idx_ff]) begin
               if (scan_max_ff) begin
                  if (rd_uses > maxu_ff) begin
                     maxu_in = rd_uses;
                  end
               end else if (!found_ff || rd_credit > best_credit_ff ||
                            (rd_credit == best_credit_ff && rd_uses < best_uses_ff)) begin
                  found_in       = 1'b1;
                  best_idx_in    = cmp_idx_ff;
                  best_credit_in = rd_credit;
                  best_uses_in   = rd_uses;
               end
            end
         end
         ST_NEW_WR: begin
            tbl_we               = 1'b1;
            tbl_waddr            = slot_idx;
            tbl_wdata            = {maxu_ff, CB'(amount_ff)};
            present_in[slot_idx] = 1'b1;
            scan_max_in          = 1'b0;
            scan_go              = 1'b1;
         end
         ST_DECIDE: begin
            if (found_ff && best_credit_ff != '0 && count_ff != '0) begin
               q_re      = 1'b1;
               head_in   = (head_ff == QB'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
               count_in  = count_ff - 1'b1;
               disp_in   = 1'b1;
               target_in = best_idx_ff;
               tbl_we    = 1'b1;
               tbl_waddr = best_idx_ff;
               tbl_wdata = {(best_uses_ff == cwd_pkg::USES_MAX) ? best_uses_ff
                                                                : best_uses_ff + 1'b1,
                            best_credit_ff - 1'b1};
               state_in  = ST_FETCH;
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_FETCH: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_disp_in   = disp_ff;
               rsp_target_in = cwd_pkg::SLOT_FIELD_BITS'(32'(target_ff));
               rsp_value_in  = disp_ff ? cwd_pkg::VALUE_FIELD_BITS'(q_rd_ff) : '0;
               rsp_status_in = status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (scan_go) begin
         scan_cnt_in = '0;
         found_in    = 1'b0;
         maxu_in     = '0;
         state_in    = ST_SCAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         present_ff   <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         present_ff   <= present_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff         <= act_in;
      slot_ff        <= slot_in;
      amount_ff      <= amount_in;
      value_ff       <= value_in;
      scan_cnt_ff    <= scan_cnt_in;
      scan_max_ff    <= scan_max_in;
      cmp_idx_ff     <= cmp_idx_in;
      found_ff       <= found_in;
      best_idx_ff    <= best_idx_in;
      best_credit_ff <= best_credit_in;
      best_uses_ff   <= best_uses_in;
      maxu_ff        <= maxu_in;
      status_ff      <= status_in;
      disp_ff        <= disp_in;
      target_ff      <= target_in;
      rsp_disp_ff    <= rsp_disp_in;
      rsp_target_ff  <= rsp_target_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_status_ff  <= rsp_status_in;
   end

   // worker table: {uses, credit}; an entry read is only used while its slot is present
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tbl_waddr] <= tbl_wdata;
      end
      if (tbl_re) begin
         tbl_rd_ff <= tbl_mem[tbl_raddr];
      end
   end

   // work queue storage
   always_ff @(posedge clock) begin
      if (q_we) begin
         q_mem[tail_ff] <= value_ff;
      end
      if (q_re) begin
         q_rd_ff <= q_mem[head_ff];
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QB + 1)'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> head_ff == tail_ff)
      else $error("empty queue with unequal pointers");

   a_no_workers_empty: assert property (@(posedge clock) disable iff (reset)
      present_ff == '0 |-> count_ff == '0)
      else $error("work queued with no workers present");

   a_dispatch_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_disp_ff |-> rsp_status_ff != cwd_pkg::STATUS_NO_WORKERS)
      else $error("dispatch reported with no workers");
`endif

endmodule

`default_nettype wire

@@ dv/credit_work_dispatcher_tb.sv @@
`timescale 1ns / 1ps

module credit_work_dispatcher_tb;

   localparam int WORKER_SLOTS = 8;
   localparam int QUEUE_DEPTH  = 16;
   localparam int VALUE_BITS   = 64;
   localparam int IDLE_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 2 * WORKER_SLOTS + 12;
   localparam int RANDOM_ITEMS = 300;

   typedef struct packed {
      logic                                 dispatched;
      logic [cwd_pkg::SLOT_FIELD_BITS-1:0]  target;
      logic [cwd_pkg::VALUE_FIELD_BITS-1:0] value;
      cwd_pkg::status_type                  status;
   } outcome_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [cwd_pkg::REQ_TDATA_BITS-1:0] req_tdata = '0;
   logic [1:0]                         req_tuser = '0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [cwd_pkg::RSP_TDATA_BITS-1:0] rsp_tdata;
   logic [2:0]                         rsp_tuser;

   // mirror of the worker table and work queue
   logic                            wk_present [WORKER_SLOTS];
   logic [cwd_pkg::CREDIT_BITS-1:0] wk_credit  [WORKER_SLOTS];
   logic [cwd_pkg::USES_BITS-1:0]   wk_uses    [WORKER_SLOTS];
   logic [VALUE_BITS-1:0]           work_fifo  [$];

   outcome_type outcomes_due [$];
   outcome_type want;

   int error_count   = 0;
   int accepted_reqs = 0;
   int seen_rsps     = 0;
   int n_dispatch    = 0;
   int n_full        = 0;
   int n_no_workers  = 0;
   int n_unknown     = 0;
   int burst_left    = 0;
   int idle_cycles   = 0;
   int pattern_left  = 0;
   int stall_mode    = 0;

   credit_work_dispatcher #(
      .WORKER_SLOTS (WORKER_SLOTS),
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .VALUE_BITS   (VALUE_BITS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   function automatic bit any_worker();
      for (int i = 0; i < WORKER_SLOTS; i++)
         if (wk_present[i])
            return 1'b1;
      return 1'b0;
   endfunction

   // most credit wins, then fewer uses, then lowest slot
   function automatic void try_dispatch(inout outcome_type res);
      bit found;
      int best;
      found = 1'b0;
      best  = 0;
      for (int i = 0; i < WORKER_SLOTS; i++) begin
         if (wk_present[i] && (!found || wk_credit[i] > wk_credit[best] ||
             (wk_credit[i] == wk_credit[best] && wk_uses[i] < wk_uses[best]))) begin
            best  = i;
            found = 1'b1;
         end
      end
      if (!found || wk_credit[best] == 0 || work_fifo.size() == 0)
         return;
      res.dispatched = 1'b1;
      res.target     = best[cwd_pkg::SLOT_FIELD_BITS-1:0];
      res.value      = work_fifo.pop_front();
      wk_credit[best] = wk_credit[best] - 1'b1;
      if (wk_uses[best] != cwd_pkg::USES_MAX)
         wk_uses[best] = wk_uses[best] + 1'b1;
   endfunction

   function automatic outcome_type apply_action(cwd_pkg::action_type act, logic [2:0] slot,
                                                logic [7:0] amount, logic [63:0] value);
      outcome_type                    res;
      logic [cwd_pkg::USES_BITS-1:0]  top_uses;
      logic [cwd_pkg::CREDIT_BITS:0]  sum;
      res        = '0;
      res.status = cwd_pkg::STATUS_OK;
      case (act)
         cwd_pkg::ACT_WORK: begin
            if (!any_worker())
               res.status = cwd_pkg::STATUS_NO_WORKERS;
            else if (work_fifo.size() >= QUEUE_DEPTH)
               res.status = cwd_pkg::STATUS_QUEUE_FULL;
            else
               work_fifo.push_back(value[VALUE_BITS-1:0]);
            try_dispatch(res);
         end
         cwd_pkg::ACT_HELLO: begin
            if (wk_present[slot]) begin
               sum = wk_credit[slot] + amount;
               wk_credit[slot] = sum[cwd_pkg::CREDIT_BITS] ? cwd_pkg::CREDIT_MAX
                                                           : sum[cwd_pkg::CREDIT_BITS-1:0];
            end else begin
               top_uses = '0;
               for (int i = 0; i < WORKER_SLOTS; i++)
                  if (wk_present[i] && wk_uses[i] > top_uses)
                     top_uses = wk_uses[i];
               wk_present[slot] = 1'b1;
               wk_credit[slot]  = amount;
               wk_uses[slot]    = top_uses;
            end
            try_dispatch(res);
         end
         cwd_pkg::ACT_READY: begin
            if (!wk_present[slot])
               res.status = cwd_pkg::STATUS_UNKNOWN;
            else if (wk_credit[slot] != cwd_pkg::CREDIT_MAX)
               wk_credit[slot] = wk_credit[slot] + 1'b1;
            try_dispatch(res);
         end
         default: begin
            if (!wk_present[slot]) begin
               res.status = cwd_pkg::STATUS_UNKNOWN;
            end else begin
               wk_present[slot] = 1'b0;
               wk_credit[slot]  = '0;
               wk_uses[slot]    = '0;
               if (!any_worker())
                  work_fifo.delete();
            end
         end
      endcase
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   // one transaction on the request side; bursts with random gaps in between
   task automatic send_action(input cwd_pkg::action_type act, input logic [2:0] slot,
                              input logic [7:0] amount, input logic [63:0] value);
      logic [cwd_pkg::REQ_TDATA_BITS-1:0] word;
      int                                 gap;
      word = '0;
      word[cwd_pkg::REQ_SLOT_LSB +: cwd_pkg::SLOT_FIELD_BITS]     = slot;
      word[cwd_pkg::REQ_AMOUNT_LSB +: cwd_pkg::AMOUNT_FIELD_BITS] = amount;
      word[cwd_pkg::REQ_VALUE_LSB +: cwd_pkg::VALUE_FIELD_BITS]   = value;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      outcomes_due.push_back(apply_action(act, slot, amount, value));
      accepted_reqs++;
   endtask

   task automatic drain_outcomes();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (outcomes_due.size() != 0) @(posedge clock);
   endtask

   task automatic dismiss_all_workers();
      for (int i = 0; i < WORKER_SLOTS; i++)
         if (wk_present[i])
            send_action(cwd_pkg::ACT_GOODBYE, i[2:0], 8'd0, 64'd0);
   endtask

   task automatic test_no_workers();
      send_action(cwd_pkg::ACT_WORK, 3'd0, 8'd0, 64'h0123_4567_89AB_CDEF);
      send_action(cwd_pkg::ACT_READY, 3'd4, 8'd0, 64'd0);
      send_action(cwd_pkg::ACT_GOODBYE, 3'd7, 8'd0, 64'd0);
      send_action(cwd_pkg::ACT_HELLO, 3'd0, 8'd0, 64'd0);
      send_action(cwd_pkg::ACT_WORK, 3'd0, 8'd0, '1);
      send_action(cwd_pkg::ACT_WORK, 3'd0, 8'd0, 64'd0);
      send_action(cwd_pkg::ACT_HELLO, 3'd7, 8'hFF, 64'd0);
      send_action(cwd_pkg::ACT_READY, 3'd0, 8'hFF, '1);
      send_action(cwd_pkg::ACT_GOODBYE, 3'd2, 8'd0, 64'd0);
      drain_outcomes();
   endtask

   // fill the queue against a worker with no credit, then let the last goodbye flush it
   task automatic test_queue_full_and_flush();
      dismiss_all_workers();
      send_action(cwd_pkg::ACT_HELLO, 3'd3, 8'd0, 64'd0);
      for (int i = 0; i <= QUEUE_DEPTH; i++)
         send_action(cwd_pkg::ACT_WORK, 3'd0, 8'd0, (i == 0) ? '1 : {$urandom, $urandom});
      send_action(cwd_pkg::ACT_HELLO, 3'd3, 8'd2, 64'd0);
      send_action(cwd_pkg::ACT_READY, 3'd3, 8'd0, 64'd0);
      send_action(cwd_pkg::ACT_WORK, 3'd0, 8'd0, 64'hAAAA_5555_AAAA_5555);
      send_action(cwd_pkg::ACT_GOODBYE, 3'd3, 8'd0, 64'd0);
      send_action(cwd_pkg::ACT_HELLO, 3'd3, 8'd4, 64'd0);
      drain_outcomes();
   endtask

   task automatic test_tie_break();
      dismiss_all_workers();
      send_action(cwd_pkg::ACT_HELLO, 3'd6, 8'd2, 64'd0);
      send_action(cwd_pkg::ACT_HELLO, 3'd1, 8'd2, 64'd0);
      repeat (4) send_action(cwd_pkg::ACT_WORK, 3'd0, 8'd0, {$urandom, $urandom});
      drain_outcomes();
   endtask

   // push one worker to the credit ceiling, then check uses are inherited by a newcomer
   task automatic test_credit_saturation();
      dismiss_all_workers();
      repeat ((int'(cwd_pkg::CREDIT_MAX) / 255) + 2)
         send_action(cwd_pkg::ACT_HELLO, 3'd5, 8'hFF, 64'd0);
      send_action(cwd_pkg::ACT_READY, 3'd5, 8'd0, 64'd0);
      send_action(cwd_pkg::ACT_HELLO, 3'd2, 8'hFF, 64'd0);
      repeat (6) send_action(cwd_pkg::ACT_WORK, 3'd0, 8'd0, {$urandom, $urandom});
      send_action(cwd_pkg::ACT_HELLO, 3'd1, 8'd0, 64'd0);
      send_action(cwd_pkg::ACT_GOODBYE, 3'd5, 8'd0, 64'd0);
      repeat (3) send_action(cwd_pkg::ACT_WORK, 3'd0, 8'd0, {$urandom, $urandom});
      drain_outcomes();
   endtask

   task automatic test_random_traffic();
      int                  pick;
      cwd_pkg::action_type act;
      logic [7:0]          amount;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45)      act = cwd_pkg::ACT_WORK;
         else if (pick < 65) act = cwd_pkg::ACT_HELLO;
         else if (pick < 90) act = cwd_pkg::ACT_READY;
         else                act = cwd_pkg::ACT_GOODBYE;
         // mostly scarce credit so the queue backs up now and then
         pick = $urandom_range(0, 9);
         if (pick < 7)      amount = 8'($urandom_range(0, 2));
         else if (pick < 9) amount = 8'($urandom_range(0, 255));
         else               amount = 8'hFF;
         send_action(act, 3'($urandom_range(0, WORKER_SLOTS - 1)), amount,
                     {$urandom, $urandom});
         if (n % 150 == 149)
            drain_outcomes();
      end
      drain_outcomes();
   endtask

   always @(posedge clock) begin
      if (pattern_left == 0) begin
         stall_mode   <= $urandom_range(0, 3);
         pattern_left <= $urandom_range(16, 96);
      end else begin
         pattern_left <= pattern_left - 1;
      end
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= 1'($urandom_range(0, 1));
         2:       rsp_tready <= (pattern_left[1:0] == 2'd0);
         default: rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_rsps++;
         if (outcomes_due.size() == 0) begin
            report_mismatch("result with no transaction outstanding");
         end else begin
            want = outcomes_due.pop_front();
            if (want.dispatched) n_dispatch++;
            if (want.status == cwd_pkg::STATUS_QUEUE_FULL) n_full++;
            if (want.status == cwd_pkg::STATUS_NO_WORKERS) n_no_workers++;
            if (want.status == cwd_pkg::STATUS_UNKNOWN) n_unknown++;
            if (rsp_tuser[0] !== want.dispatched)
               report_mismatch($sformatf("dispatched %b, want %b", rsp_tuser[0],
                                         want.dispatched));
            if (rsp_tuser[2:1] !== want.status)
               report_mismatch($sformatf("status %0d, want %s", rsp_tuser[2:1],
                                         want.status.name()));
            if (rsp_tdata[cwd_pkg::SLOT_FIELD_BITS-1:0] !== want.target)
               report_mismatch($sformatf("target_worker %0d, want %0d",
                                         rsp_tdata[cwd_pkg::SLOT_FIELD_BITS-1:0],
                                         want.target));
            if (rsp_tdata[cwd_pkg::SLOT_FIELD_BITS +: cwd_pkg::VALUE_FIELD_BITS] !== want.value)
               report_mismatch($sformatf("sent_value %h, want %h",
                  rsp_tdata[cwd_pkg::SLOT_FIELD_BITS +: cwd_pkg::VALUE_FIELD_BITS],
                  want.value));
            if (rsp_tdata[cwd_pkg::RSP_TDATA_BITS-1 -: cwd_pkg::RSP_PAD_BITS] !== '0)
               report_mismatch("rsp_tdata padding not zero");
         end
      end
   end

   // ends the run if neither side moves a transaction for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("stalled for %0d cycles, %0d results outstanding", idle_cycles,
                  outcomes_due.size());
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      for (int i = 0; i < WORKER_SLOTS; i++) begin
         wk_present[i] = 1'b0;
         wk_credit[i]  = '0;
         wk_uses[i]    = '0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_no_workers();
      test_queue_full_and_flush();
      test_tie_break();
      test_credit_saturation();
      test_random_traffic();
      drain_outcomes();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("%0d requests, %0d results: %0d dispatches, %0d queue-full drops,",
               accepted_reqs, seen_rsps, n_dispatch, n_full);
      $display("%0d no-worker drops, %0d unknown-worker actions, %0d mismatches",
               n_no_workers, n_unknown, error_count);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
